@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/frit_pkg.sv @@
package frit_pkg;

	localparam int unsigned ENTRY_W = 48;

	typedef enum logic [2:0] {
		ACT_MAP    = 3'd0,
		ACT_INTERN = 3'd1,
		ACT_READ   = 3'd2,
		ACT_LOAD   = 3'd3,
		ACT_CLEAR  = 3'd4
	} frit_action_t;

	localparam logic [1:0] REG_DEFAULT_FONT  = 2'd0;
	localparam logic [1:0] REG_DEFAULT_STYLE = 2'd1;
	localparam logic [1:0] REG_DEFAULT_SIZE  = 2'd2;

	localparam logic [14:0] DEFAULT_SIZE_RST = 15'd12;
	localparam logic [15:0] INDEX_NONE       = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPEND,
		ST_READ,
		ST_RDOUT
	} frit_state_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] font_id;
		logic [15:0] style;
		logic [14:0] text_size;
		logic        unicode;
		logic [15:0] entry_index;
	} frit_cmd_t;

	typedef struct packed {
		logic [15:0] result_index;
		logic        found;
		logic        table_full;
		logic [15:0] out_font;
		logic [15:0] out_style;
		logic [14:0] out_size;
		logic        out_unicode;
	} frit_rsp_t;

endpackage

@@ rtl/frit_ram.sv @@
module frit_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/font_record_intern_table_unit.sv @@
// Map and intern scan in stored order and stop at a hit; one stored entry is
// compared per cycle through the single read port of the entry RAM. Intern with
// a miss then appends. Read: ST_READ, then ST_RDOUT if stored. Load: append.
// One transaction at a time; busy stays high until the result strobe.
// Reset empties the table and restores the default record; no RAM clearing.
// Each result is on rsp for one cycle with done; the receiver cannot stall.
`include "assert_macros.svh"

module font_record_intern_table_unit #(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  frit_pkg::frit_cmd_t cmd,
	output logic                done,
	output frit_pkg::frit_rsp_t rsp,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	import frit_pkg::*;

	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned IW = $clog2(TABLE_DEPTH);

	frit_state_t state_q, state_d;
	frit_cmd_t   cmd_q;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] scan_q, scan_d;
	logic [CW-1:0] pidx_q, pidx_d;
	logic          pend_q, pend_d;
	logic          done_q;
	frit_rsp_t     rsp_q, rsp_d;
	logic          emit;
	logic          accept;
	logic          cfg_wr;
	logic          wr_en;
	logic [IW-1:0] raddr;
	logic [ENTRY_W-1:0] rdata;
	logic [ENTRY_W-1:0] key;
	logic          hit;
	logic          issue;
	logic          idx_ok;
	logic [15:0] dflt_font_q;
	logic [15:0] dflt_style_q;
	logic [14:0] dflt_size_q;

	frit_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(cnt_q[IW-1:0]),
		.wdata(key),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	assign key    = {cmd_q.font_id, cmd_q.style, cmd_q.unicode, cmd_q.text_size};
	assign hit    = pend_q && (rdata == key);
	assign issue  = (scan_q < cnt_q);
	assign idx_ok = ({1'b0, cmd_q.entry_index} < 17'(cnt_q));

	always_comb begin
		case (paddr[3:2])
			REG_DEFAULT_FONT:  prdata = {16'd0, dflt_font_q};
			REG_DEFAULT_STYLE: prdata = {16'd0, dflt_style_q};
			REG_DEFAULT_SIZE:  prdata = {17'd0, dflt_size_q};
			default:           prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_font_q  <= 16'd0;
			dflt_style_q <= 16'd0;
			dflt_size_q  <= DEFAULT_SIZE_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_DEFAULT_FONT:  dflt_font_q  <= pwdata[15:0];
				REG_DEFAULT_STYLE: dflt_style_q <= pwdata[15:0];
				REG_DEFAULT_SIZE:  dflt_size_q  <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			scan_q  <= '0;
			pidx_q  <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			scan_q  <= scan_d;
			pidx_q  <= pidx_d;
			pend_q  <= pend_d;
			done_q  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		scan_d  = scan_q;
		pidx_d  = pidx_q;
		pend_d  = pend_q;
		emit    = 1'b0;
		rsp_d   = '0;
		wr_en   = 1'b0;
		raddr   = scan_q[IW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd.action)
						ACT_MAP, ACT_INTERN: begin
							state_d = ST_SCAN;
							scan_d  = '0;
							pend_d  = 1'b0;
						end
						ACT_READ: state_d = ST_READ;
						ACT_LOAD: state_d = ST_APPEND;
						ACT_CLEAR: begin
							cnt_d              = '0;
							emit               = 1'b1;
							rsp_d.result_index = INDEX_NONE;
						end
						default: emit = 1'b1;
					endcase
				end
			end
			ST_SCAN: begin
				if (hit) begin
					emit               = 1'b1;
					rsp_d.result_index = 16'(pidx_q);
					rsp_d.found        = 1'b1;
					state_d            = ST_IDLE;
				end else if (!issue && !pend_q) begin
					if (cmd_q.action == ACT_INTERN) begin
						state_d = ST_APPEND;
					end else begin
						emit               = 1'b1;
						rsp_d.result_index = 16'(cnt_q) - 16'd1;
						state_d            = ST_IDLE;
					end
				end else begin
					pend_d = issue;
					pidx_d = scan_q;
					scan_d = scan_q + CW'(1);
				end
			end
			ST_APPEND: begin
				emit    = 1'b1;
				state_d = ST_IDLE;
				if (cnt_q < CW'(TABLE_DEPTH)) begin
					wr_en              = 1'b1;
					cnt_d              = cnt_q + CW'(1);
					rsp_d.result_index = 16'(cnt_q);
				end else begin
					rsp_d.table_full   = 1'b1;
					rsp_d.result_index = 16'(cnt_q) - 16'd1;
				end
			end
			ST_READ: begin
				raddr = cmd_q.entry_index[IW-1:0];
				if (idx_ok) begin
					state_d = ST_RDOUT;
				end else begin
					emit               = 1'b1;
					rsp_d.result_index = cmd_q.entry_index;
					rsp_d.out_font     = dflt_font_q;
					rsp_d.out_style    = dflt_style_q;
					rsp_d.out_size     = dflt_size_q;
					state_d            = ST_IDLE;
				end
			end
			ST_RDOUT: begin
				emit               = 1'b1;
				rsp_d.result_index = cmd_q.entry_index;
				rsp_d.out_font     = rdata[47:32];
				rsp_d.out_style    = rdata[31:16];
				rsp_d.out_unicode  = rdata[15];
				rsp_d.out_size     = rdata[14:0];
				state_d            = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`ASSERT_IMPLIES(a_done_idle, clk, arst_n, done, !busy)
	`ASSERT_ALWAYS(a_cnt_range, clk, arst_n, cnt_q <= CW'(TABLE_DEPTH))
	`ASSERT_IMPLIES(a_found_full, clk, arst_n, done, !(rsp.found && rsp.table_full))
	`ASSERT_NEXT(a_accept_moves, clk, arst_n, start && !busy, busy || done)
	`ASSERT_IMPLIES(a_write_room, clk, arst_n, wr_en, cnt_q < CW'(TABLE_DEPTH))

endmodule

@@ verif/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import frit_pkg::*;

	localparam int unsigned TABLE_DEPTH = 256;
	localparam logic [2:0] ACT_RSVD_FIRST = 3'd5;
	localparam logic [2:0] ACT_RSVD_LAST = 3'd7;
	localparam int unsigned IDLE_PCT [4] = '{0, 63, 0, 26};
	localparam int unsigned PHASE_END [4] = '{170, 480, 565, 650};

	typedef struct packed {
		logic [15:0] font;
		logic [15:0] style;
		logic        unicode;
		logic [14:0] size;
	} record_t;

	class font_table_tracker;
		record_t     entries [TABLE_DEPTH];
		int unsigned stored;
		logic [15:0] dflt_font;
		logic [15:0] dflt_style;
		logic [14:0] dflt_size;
		frit_rsp_t   awaited [$];
		int unsigned mismatches;
		int unsigned per_action [8];
		int unsigned hits;
		int unsigned refused;
		int unsigned default_reads;
		int unsigned reg_writes;

		function new();
			stored = 0;
			dflt_font = '0;
			dflt_style = '0;
			dflt_size = DEFAULT_SIZE_RST;
			mismatches = 0;
			hits = 0;
			refused = 0;
			default_reads = 0;
			reg_writes = 0;
			foreach (per_action[i]) per_action[i] = 0;
		endfunction

		function void write_register(logic [1:0] r, logic [31:0] v);
			reg_writes++;
			case (r)
			REG_DEFAULT_FONT: dflt_font = v[15:0];
			REG_DEFAULT_STYLE: dflt_style = v[15:0];
			REG_DEFAULT_SIZE: dflt_size = v[14:0];
			default: ;
			endcase
		endfunction

		function logic [15:0] last_index();
			return 16'(stored - 1);
		endfunction

		function void lookup(record_t r, output logic hit, output logic [15:0] idx);
			hit = 1'b0;
			idx = last_index();
			for (int i = 0; i < stored && !hit; i++) begin
				if (entries[i] == r) begin
					hit = 1'b1;
					idx = 16'(i);
				end
			end
		endfunction

		function void append(record_t r, output logic full, output logic [15:0] idx);
			if (stored >= TABLE_DEPTH) begin
				full = 1'b1;
				refused++;
			end else begin
				full = 1'b0;
				entries[stored] = r;
				stored++;
			end
			idx = last_index();
		endfunction

		function void note_command(frit_cmd_t c);
			frit_rsp_t   e;
			record_t     r;
			logic        hit;
			logic        full;
			logic [15:0] idx;
			e = '0;
			hit = 1'b0;
			full = 1'b0;
			r = '{font: c.font_id, style: c.style, unicode: c.unicode, size: c.text_size};
			per_action[c.action]++;
			case (c.action)
			ACT_MAP: begin
				lookup(r, hit, idx);
				e.result_index = idx;
			end
			ACT_INTERN: begin
				lookup(r, hit, idx);
				if (!hit) append(r, full, idx);
				e.result_index = idx;
			end
			ACT_READ: begin
				e.result_index = c.entry_index;
				if (c.entry_index < stored) begin
					e.out_font = entries[c.entry_index].font;
					e.out_style = entries[c.entry_index].style;
					e.out_size = entries[c.entry_index].size;
					e.out_unicode = entries[c.entry_index].unicode;
				end else begin
					e.out_font = dflt_font;
					e.out_style = dflt_style;
					e.out_size = dflt_size;
					default_reads++;
				end
			end
			ACT_LOAD: begin
				append(r, full, idx);
				e.result_index = idx;
			end
			ACT_CLEAR: begin
				stored = 0;
				e.result_index = INDEX_NONE;
			end
			default: ;
			endcase
			e.found = hit;
			e.table_full = full;
			if (hit) hits++;
			awaited.push_back(e);
		endfunction

		function void flag(string field, logic [15:0] want, logic [15:0] got);
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		endfunction

		function void check_response(frit_rsp_t r);
			frit_rsp_t e;
			if (awaited.size() == 0) begin
				mismatches++;
				$display("%0t: result with no transaction outstanding: %h", $time, r);
				return;
			end
			e = awaited.pop_front();
			if (r.result_index !== e.result_index)
				flag("result_index", e.result_index, r.result_index);
			if (r.found !== e.found) flag("found", e.found, r.found);
			if (r.table_full !== e.table_full) flag("table_full", e.table_full, r.table_full);
			if (r.out_font !== e.out_font) flag("out_font", e.out_font, r.out_font);
			if (r.out_style !== e.out_style) flag("out_style", e.out_style, r.out_style);
			if (r.out_size !== e.out_size) flag("out_size", e.out_size, r.out_size);
			if (r.out_unicode !== e.out_unicode)
				flag("out_unicode", e.out_unicode, r.out_unicode);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	frit_cmd_t   cmd = '0;
	logic        done;
	frit_rsp_t   rsp;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	font_table_tracker sb;
	int unsigned       idle_pct = 0;
	int unsigned       sent = 0;

	font_record_intern_table_unit #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_response(rsp);
	end

	function automatic frit_cmd_t cmd_of(logic [2:0] a, record_t r, logic [15:0] idx);
		frit_cmd_t c;
		c.action = a;
		c.font_id = r.font;
		c.style = r.style;
		c.text_size = r.size;
		c.unicode = r.unicode;
		c.entry_index = idx;
		return c;
	endfunction

	function automatic record_t fresh_record();
		record_t r;
		if ($urandom_range(0, 1) == 0) begin
			r.font = 16'($urandom);
			r.style = 16'($urandom);
			r.size = 15'($urandom);
			r.unicode = 1'($urandom);
		end else begin
			r.font = 16'($urandom_range(0, 3));
			r.style = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			r.size = 15'($urandom_range(10, 12));
			r.unicode = 1'($urandom);
		end
		return r;
	endfunction

	function automatic record_t stored_record();
		return sb.entries[$urandom_range(0, sb.stored - 1)];
	endfunction

	function automatic frit_cmd_t pick_query();
		record_t     r;
		logic [15:0] idx;
		int unsigned k;
		k = $urandom_range(0, 99);
		r = fresh_record();
		idx = 16'($urandom);
		if (k < 30 && sb.stored != 0) begin
			r = stored_record();
			if (k >= 22) r = r ^ (48'd1 << $urandom_range(0, 47));
			return cmd_of(ACT_MAP, r, idx);
		end
		if (k < 40) return cmd_of(ACT_MAP, r, idx);
		if (k < 55) begin
			if (k < 48 && sb.stored != 0) r = stored_record();
			return cmd_of(ACT_INTERN, r, idx);
		end
		if (k < 72 && sb.stored != 0)
			return cmd_of(ACT_READ, r, 16'($urandom_range(0, sb.stored - 1)));
		if (k < 80) begin
			case ($urandom_range(0, 2))
			0: idx = 16'(sb.stored + $urandom_range(0, 3));
			1: idx = INDEX_NONE;
			default: ;
			endcase
			return cmd_of(ACT_READ, r, idx);
		end
		if (k < 88) begin
			if (k < 84 && sb.stored != 0) r = stored_record();
			return cmd_of(ACT_LOAD, r, idx);
		end
		if (k < 91) return cmd_of(ACT_CLEAR, r, idx);
		if (k < 95)
			return cmd_of(3'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST)), r, idx);
		r.font = 16'($urandom);
		r.style = 16'($urandom);
		r.size = 15'($urandom);
		r.unicode = 1'($urandom);
		return cmd_of(3'($urandom), r, idx);
	endfunction

	task automatic issue(input frit_cmd_t c);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		// hold start high into the next transaction when no gap follows
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		sb.note_command(c);
		sent++;
	endtask

	task automatic settle();
		start <= 1'b0;
		do @(negedge clk); while (sb.awaited.size() != 0);
		@(posedge clk);
	endtask

	task automatic write_default(input logic [1:0] r, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_register(r, v);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic directed_items();
		record_t ones;
		record_t zero;
		record_t other;
		record_t plain;
		ones = '{font: 16'hFFFF, style: 16'hFFFF, unicode: 1'b1, size: 15'h7FFF};
		zero = '0;
		other = '{font: 16'h1234, style: 16'h8001, unicode: 1'b0, size: 15'h4000};
		plain = ones;
		plain.unicode = 1'b0;
		issue(cmd_of(ACT_MAP, ones, 16'h0000));
		issue(cmd_of(ACT_READ, zero, 16'h0000));
		issue(cmd_of(ACT_INTERN, ones, 16'hFFFF));
		issue(cmd_of(ACT_INTERN, ones, 16'h0000));
		issue(cmd_of(ACT_MAP, ones, 16'h0000));
		issue(cmd_of(ACT_INTERN, zero, 16'h0000));
		issue(cmd_of(ACT_LOAD, ones, 16'h0000));
		issue(cmd_of(ACT_MAP, ones, 16'h0000));
		issue(cmd_of(ACT_MAP, other, 16'h0000));
		issue(cmd_of(ACT_MAP, plain, 16'h0000));
		issue(cmd_of(ACT_READ, zero, 16'h0000));
		issue(cmd_of(ACT_READ, zero, 16'h0001));
		issue(cmd_of(ACT_READ, zero, 16'h0003));
		issue(cmd_of(ACT_READ, zero, INDEX_NONE));
		issue(cmd_of(ACT_RSVD_FIRST, ones, INDEX_NONE));
		issue(cmd_of(ACT_RSVD_FIRST + 3'd1, ones, INDEX_NONE));
		issue(cmd_of(ACT_RSVD_LAST, ones, INDEX_NONE));
		issue(cmd_of(ACT_CLEAR, ones, 16'h0000));
		issue(cmd_of(ACT_MAP, ones, 16'h0000));
		issue(cmd_of(ACT_READ, zero, 16'h0000));
		issue(cmd_of(ACT_LOAD, zero, 16'h0000));
		issue(cmd_of(ACT_INTERN, plain, 16'h0000));
		issue(cmd_of(ACT_READ, zero, 16'h0001));
	endtask

	task automatic fill_table();
		issue(cmd_of(ACT_CLEAR, fresh_record(), 16'h0000));
		while (sb.stored < TABLE_DEPTH)
			issue(cmd_of(ACT_LOAD, fresh_record(), 16'($urandom)));
		issue(cmd_of(ACT_INTERN, fresh_record(), 16'h0000));
		issue(cmd_of(ACT_LOAD, fresh_record(), 16'h0000));
		issue(cmd_of(ACT_INTERN, stored_record(), 16'h0000));
		issue(cmd_of(ACT_MAP, sb.entries[TABLE_DEPTH - 1], 16'h0000));
		issue(cmd_of(ACT_MAP, fresh_record(), 16'h0000));
		issue(cmd_of(ACT_READ, fresh_record(), 16'(TABLE_DEPTH - 1)));
		issue(cmd_of(ACT_READ, fresh_record(), 16'(TABLE_DEPTH)));
	endtask

	task automatic run_session();
		int unsigned n;
		if ($urandom_range(0, 3) == 0) issue(cmd_of(ACT_CLEAR, fresh_record(), 16'($urandom)));
		n = $urandom_range(0, 20);
		repeat (n) begin
			if ($urandom_range(0, 9) < 6)
				issue(cmd_of(ACT_INTERN, fresh_record(), 16'($urandom)));
			else
				issue(cmd_of(ACT_LOAD, fresh_record(), 16'($urandom)));
		end
		n = $urandom_range(8, 30);
		repeat (n) issue(pick_query());
	endtask

	initial begin
		int unsigned undefined_cmds;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_items();
		for (int p = 0; p < 4; p++) begin
			settle();
			case (p)
			0: begin
				write_default(REG_DEFAULT_FONT, 32'h0000_FFFF);
				write_default(REG_DEFAULT_STYLE, 32'h0000_0000);
				write_default(REG_DEFAULT_SIZE, 32'hFFFF_FFFF);
			end
			1: begin
				write_default(REG_DEFAULT_FONT, 32'h0000_0000);
				write_default(REG_DEFAULT_STYLE, 32'h0000_FFFF);
				write_default(REG_DEFAULT_SIZE, 32'h0000_0000);
			end
			default: begin
				write_default(REG_DEFAULT_FONT, $urandom);
				write_default(REG_DEFAULT_STYLE, $urandom);
				write_default(REG_DEFAULT_SIZE, $urandom);
			end
			endcase
			idle_pct = IDLE_PCT[p];
			if (p == 1) fill_table();
			while (sent < PHASE_END[p]) run_session();
		end
		settle();
		repeat (16) @(posedge clk);
		undefined_cmds = sb.per_action[5] + sb.per_action[6] + sb.per_action[7];
		$display("covered %0d transactions: %0d map, %0d intern, %0d read, %0d load, %0d clear, %0d undefined",
			sent, sb.per_action[ACT_MAP], sb.per_action[ACT_INTERN], sb.per_action[ACT_READ],
			sb.per_action[ACT_LOAD], sb.per_action[ACT_CLEAR], undefined_cmds);
		$display("%0d search hits, %0d refused appends, %0d default reads, %0d register writes",
			sb.hits, sb.refused, sb.default_reads, sb.reg_writes);
		if (sb.mismatches == 0 && sb.awaited.size() == 0)
			$display("font_record_intern_table_unit regression: pass");
		else
			$display("font_record_intern_table_unit regression: fail");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("font_record_intern_table_unit regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/frit_pkg.sv
rtl/frit_ram.sv
rtl/font_record_intern_table_unit.sv
verif/tb_top.sv
